// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication into the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Constants and types for the 2x2 box filter RGB downscaler.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = PIX_W + 1;
    localparam int QUAD_W  = PIX_W + 2;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 1;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = COL_W - 1;

    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd2048;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd2048;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_pair_sum;

endpackage

// ===== hw/rtl/rgb_2x2_box_downscale_top.sv =====
// ----------------------------------------------------------------------------
// rgb_2x2_box_downscale_top
// Halves a raster-order RGB frame by averaging each 2x2 block of pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock with no gaps of its own; the only pause comes
// from o_stall when the output side holds i_stall. An output pixel is built
// from its block's bottom-right pixel through the line memory read and the
// stage 1 register, then the output register. The line memory holds
// MAX_WIDTH/2 pair sums and sees at most one read or one write per clock.
// It is not cleared after reset; a full frame always writes an entry before
// reading it. Odd last columns and rows give no output; o_frame_last marks
// the final output pixel of the frame.
`include "assert_macros.svh"

module rgb_2x2_box_downscale_top
    import rbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,

    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_pixel_blue,
    input  logic [PIX_W-1:0] i_pixel_green,
    input  logic [PIX_W-1:0] i_pixel_red,

    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_out_blue,
    output logic [PIX_W-1:0] o_out_green,
    output logic [PIX_W-1:0] o_out_red,
    output logic             o_frame_last
);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [3*PIX_W-1:0] r_held;

    t_pair_sum r_line [LINE_DEPTH];
    t_pair_sum r_rd;

    logic      r_s1_v;
    t_pair_sum r_s1_sum;
    logic      r_s1_last;

    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [COL_W-1:0] c;
    logic [ROW_W:0]   row_x;
    logic [ROW_W-1:0] row;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [LINE_AW-1:0] idx;
    t_pair_sum sum;
    logic      last;
    logic      accept;
    logic      load_out;
    logic      emits;
    logic [QUAD_W-1:0] q_blue;
    logic [QUAD_W-1:0] q_green;
    logic [QUAD_W-1:0] q_red;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0)
            w_eff = CFG_W'(1);
        else if (int'(r_width) > MAX_WIDTH)
            w_eff = CFG_W'(MAX_WIDTH);
        else
            w_eff = r_width;

        if (r_height == '0)
            h_eff = CFG_W'(1);
        else if (int'(r_height) > MAX_HEIGHT)
            h_eff = CFG_W'(MAX_HEIGHT);
        else
            h_eff = r_height;
    end

    // position of the incoming pixel, and the one after it
    always_comb begin
        c     = r_col;
        row_x = {1'b0, r_row};
        if (int'(r_col) >= int'(w_eff)) begin
            c     = '0;
            row_x = row_x + (ROW_W+1)'(1);
        end
        if (int'(row_x) >= int'(h_eff))
            row_x = '0;
        row = row_x[ROW_W-1:0];

        col_inc = {1'b0, c} + (COL_W+1)'(1);
        row_inc = {1'b0, row} + (ROW_W+1)'(1);
        n_col   = col_inc[COL_W-1:0];
        n_row   = row;
        if (int'(col_inc) >= int'(w_eff)) begin
            n_col = '0;
            n_row = row_inc[ROW_W-1:0];
            if (int'(row_inc) >= int'(h_eff))
                n_row = '0;
        end

        idx = c[COL_W-1:1];

        sum.blue  = {1'b0, r_held[PIX_W-1:0]}         + {1'b0, i_pixel_blue};
        sum.green = {1'b0, r_held[2*PIX_W-1:PIX_W]}   + {1'b0, i_pixel_green};
        sum.red   = {1'b0, r_held[3*PIX_W-1:2*PIX_W]} + {1'b0, i_pixel_red};

        last = (int'(idx) == int'(w_eff >> 1) - 1)
            && (int'(row >> 1) == int'(h_eff >> 1) - 1);
    end

    assign load_out = r_s1_v && !(o_valid && i_stall);
    assign o_stall  = r_s1_v && !load_out;
    assign accept   = i_valid && !o_stall;
    assign emits    = c[0] && row[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!c[0])
                r_held <= {i_pixel_red, i_pixel_green, i_pixel_blue};
        end
    end

    // line memory: even rows write pair sums, odd rows read them back
    always_ff @(posedge i_clk) begin
        if (accept && c[0]) begin
            if (!row[0])
                r_line[idx] <= sum;
            else
                r_rd <= r_line[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_v <= 1'b0;
        else if (accept && emits)
            r_s1_v <= 1'b1;
        else if (load_out)
            r_s1_v <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (accept && emits) begin
            r_s1_sum  <= sum;
            r_s1_last <= last;
        end
    end

    assign q_blue  = {1'b0, r_s1_sum.blue}  + {1'b0, r_rd.blue};
    assign q_green = {1'b0, r_s1_sum.green} + {1'b0, r_rd.green};
    assign q_red   = {1'b0, r_s1_sum.red}   + {1'b0, r_rd.red};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            o_valid <= 1'b0;
        else if (load_out)
            o_valid <= 1'b1;
        else if (!i_stall)
            o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_out_blue   <= q_blue[QUAD_W-1:2];
            o_out_green  <= q_green[QUAD_W-1:2];
            o_out_red    <= q_red[QUAD_W-1:2];
            o_frame_last <= r_s1_last;
        end
    end

    `ASSERT_CLK(a_stall_needs_s1, o_stall |-> r_s1_v, "stall without a pending request")
    `ASSERT_NEXT(a_emit_fills_s1, accept && emits, r_s1_v,
        "bottom-right pixel did not reach stage 1")
    `ASSERT_NEXT(a_s1_drains, r_s1_v && !(o_valid && i_stall), o_valid,
        "stage 1 request did not move to output")

endmodule
